/* rtl/vpd_pkg.sv */
// Shared constants, register codes and state type for the V/f drive.
`timescale 1ns / 1ps
package vpd_pkg;

  localparam int FIELD_W        = 16;
  localparam int PHASE_W        = 32;
  localparam int TRIG_W         = 15;
  localparam int DIGIT_W        = 8;
  localparam int SINE_DEPTH_DEF = 1024;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_SLOPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTAGE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN  = 3'd5;

  localparam logic [FIELD_W-1:0] RST_MIN_FREQ    = 16'd0;
  localparam logic [FIELD_W-1:0] RST_MAX_FREQ    = 16'd65535;
  localparam logic [FIELD_W-1:0] RST_RAMP_STEP   = 16'd5;
  localparam logic [FIELD_W-1:0] RST_VOLT_SLOPE  = 16'd0;
  localparam logic [FIELD_W-1:0] RST_MAX_VOLTAGE = 16'd65535;
  localparam logic [FIELD_W-1:0] RST_PHASE_GAIN  = 16'd2147;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_ROM,
    ST_SCALE,
    ST_HOLD
  } vpd_state_t;

endpackage

/* rtl/vpd_smul.sv */
// Digit-serial unsigned multiplier, one digit of b per cycle, LSB first.
`timescale 1ns / 1ps
module vpd_smul #(
  parameter int AW = 16,
  parameter int BW = 16,
  parameter int DW = vpd_pkg::DIGIT_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            done,
  output logic [AW+BW-1:0] prod
);

  localparam int BWP   = ((BW + DW - 1) / DW) * DW;
  localparam int STEPS = BWP / DW;
  localparam int CW    = $clog2(STEPS + 1);

  logic [AW-1:0]         a_r;
  logic [AW+BWP-1:0]     p_r, p_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [AW+DW-1:0]      sum;
  logic [AW+DW+BWP-1:0]  p_wide;

  always_comb begin
    sum    = (AW+DW)'(p_r[AW+BWP-1:BWP]) + (AW+DW)'(a_r) * (AW+DW)'(p_r[DW-1:0]);
    p_wide = {sum, p_r[BWP-1:0]};
    p_nxt  = p_r;
    cnt_nxt = cnt_r;
    if (start) begin
      p_nxt   = {AW'(0), BWP'(b)};
      cnt_nxt = CW'(STEPS);
    end else if (cnt_r != '0) begin
      p_nxt   = p_wide[AW+DW+BWP-1:DW];
      cnt_nxt = cnt_r - 1'b1;
    end
    done_nxt = !start && (cnt_r == CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
    end
    p_r <= p_nxt;
  end

  assign done = done_r;
  assign prod = p_r[AW+BW-1:0];

endmodule

/* rtl/vpd_sine_rom.sv */
// Quarter-wave Q15 sine ROM, two registered read ports.
`timescale 1ns / 1ps
module vpd_sine_rom #(
  parameter int SINE_TABLE_DEPTH = vpd_pkg::SINE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr_a,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr_b,
  output logic [vpd_pkg::TRIG_W-1:0]            data_a,
  output logic [vpd_pkg::TRIG_W-1:0]            data_b
);

  import vpd_pkg::*;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned TaylorDiv [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef logic [TRIG_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

  // Truncated Taylor series of sin(pi/2 * k / depth) in Q30, scaled to Q15.
  function automatic rom_t rom_init();
    rom_t              tbl;
    longint unsigned   x, x2, term, v, kk;
    longint            s;
    int                k, n;
    for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      kk   = longint'(k);
      x    = (HalfPiQ30 * kk) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(x);
      for (n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / TaylorDiv[n];
        if ((n % 2) == 1) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      v = (longint'(s) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tbl[k] = TRIG_W'(v);
    end
    return tbl;
  endfunction

  localparam rom_t Rom = rom_init();

  logic [TRIG_W-1:0] data_a_r, data_b_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_a_r <= Rom[addr_a];
      data_b_r <= Rom[addr_b];
    end
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule

/* rtl/volts_per_hertz_drive.sv */
// Top level of the open-loop V/f drive: config regs, sequencer, datapath.
//
//  port group | dir | transaction carries
//  in_*       | in  | freq_cmd
//  out_*      | out | out_freq, out_voltage, out_phase, v_alpha, v_beta
//  cfg_*      | in  | register writes and reads, APB style
//
// out_tvalid is set after three digit-serial multiply passes (load, two 8-bit digit steps
// each) and the ROM read between the second and third. A transaction is taken only in
// the idle state, so the next accept waits until the sequencer is back in idle.
// A result waiting on out_tready does not block the next accept; the following
// result then waits in the hold state with in_tready low.
// rst_n is synchronous; it clears state and phase and restores config defaults.
`timescale 1ns / 1ps
module volts_per_hertz_drive #(
  parameter int SINE_TABLE_DEPTH = vpd_pkg::SINE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [vpd_pkg::FIELD_W-1:0]    in_tdata,     // [15:0] freq_cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [5*vpd_pkg::FIELD_W-1:0]  out_tdata,    // out_freq, out_voltage,
                                                       // out_phase, v_alpha, v_beta
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [vpd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [vpd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [vpd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  import vpd_pkg::*;

  localparam int D4  = 4 * SINE_TABLE_DEPTH;
  localparam int IBW = $clog2(D4 + 1);
  localparam int IW  = $clog2(D4);
  localparam int RW  = $clog2(SINE_TABLE_DEPTH + 1);

  // Config registers
  logic [FIELD_W-1:0] min_freq_r, max_freq_r, ramp_step_r;
  logic [FIELD_W-1:0] volt_slope_r, max_voltage_r, phase_gain_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic cfg_wr;

  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_freq_r    <= RST_MIN_FREQ;
      max_freq_r    <= RST_MAX_FREQ;
      ramp_step_r   <= RST_RAMP_STEP;
      volt_slope_r  <= RST_VOLT_SLOPE;
      max_voltage_r <= RST_MAX_VOLTAGE;
      phase_gain_r  <= RST_PHASE_GAIN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN_FREQ:    min_freq_r    <= cfg_pwdata[FIELD_W-1:0];
        REG_MAX_FREQ:    max_freq_r    <= cfg_pwdata[FIELD_W-1:0];
        REG_RAMP_STEP:   ramp_step_r   <= cfg_pwdata[FIELD_W-1:0];
        REG_VOLT_SLOPE:  volt_slope_r  <= cfg_pwdata[FIELD_W-1:0];
        REG_MAX_VOLTAGE: max_voltage_r <= cfg_pwdata[FIELD_W-1:0];
        REG_PHASE_GAIN:  phase_gain_r  <= cfg_pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MIN_FREQ:    cfg_prdata = CFG_DATA_W'(min_freq_r);
      REG_MAX_FREQ:    cfg_prdata = CFG_DATA_W'(max_freq_r);
      REG_RAMP_STEP:   cfg_prdata = CFG_DATA_W'(ramp_step_r);
      REG_VOLT_SLOPE:  cfg_prdata = CFG_DATA_W'(volt_slope_r);
      REG_MAX_VOLTAGE: cfg_prdata = CFG_DATA_W'(max_voltage_r);
      REG_PHASE_GAIN:  cfg_prdata = CFG_DATA_W'(phase_gain_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // Sequencer
  vpd_state_t state_r, state_nxt;
  logic in_acc, mul_start, idx_start, rom_en, scale_start, out_load, slot_free;
  logic vmul_done, pmul_done, idx_done, amul_done, bmul_done;

  assign slot_free = !out_tvalid || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:   if (vmul_done) state_nxt = ST_IDX;
      ST_IDX:   if (idx_done) state_nxt = ST_ROM;
      ST_ROM:   state_nxt = ST_SCALE;
      ST_SCALE: if (amul_done) state_nxt = slot_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    mul_start   = 1'b0;
    idx_start   = 1'b0;
    rom_en      = 1'b0;
    scale_start = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mul_start = in_tvalid;
      end
      ST_MUL:   idx_start   = vmul_done;
      ST_IDX:   rom_en      = idx_done;
      ST_ROM:   scale_start = 1'b1;
      ST_SCALE: out_load    = amul_done && slot_free;
      ST_HOLD:  out_load    = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Ramp toward target, then clamp; min wins over max
  logic [FIELD_W-1:0] freq_now_r;
  logic [FIELD_W-1:0] target, f_ramp, f_new, diff;
  logic [FIELD_W:0]   f_up;

  assign target = in_tdata;

  always_comb begin
    f_up   = {1'b0, freq_now_r} + {1'b0, ramp_step_r};
    diff   = freq_now_r - target;
    f_ramp = freq_now_r;
    if (freq_now_r < target) begin
      f_ramp = (f_up > {1'b0, target}) ? target : f_up[FIELD_W-1:0];
    end else if (freq_now_r > target) begin
      f_ramp = (ramp_step_r > diff) ? target : freq_now_r - ramp_step_r;
    end
    f_new = f_ramp;
    if (f_new > max_freq_r) f_new = max_freq_r;
    if (f_new < min_freq_r) f_new = min_freq_r;
  end

  logic [PHASE_W-1:0] phase_acc_r, phase_sum;
  logic [FIELD_W-1:0] volt_r, volt_nxt;
  logic [2*FIELD_W-1:0] vprod, pprod;

  vpd_smul #(.AW(FIELD_W), .BW(FIELD_W), .DW(DIGIT_W)) u_vmul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(f_new), .b(volt_slope_r),
    .done(vmul_done), .prod(vprod)
  );

  vpd_smul #(.AW(FIELD_W), .BW(FIELD_W), .DW(DIGIT_W)) u_pmul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(f_new), .b(phase_gain_r),
    .done(pmul_done), .prod(pprod)
  );

  assign phase_sum = phase_acc_r + pprod;
  assign volt_nxt  = (vprod[2*FIELD_W-1:FIELD_W] > max_voltage_r) ?
                     max_voltage_r : vprod[2*FIELD_W-1:FIELD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_now_r  <= '0;
      phase_acc_r <= '0;
    end else begin
      if (in_acc) freq_now_r <= f_new;
      if (idx_start) phase_acc_r <= phase_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (idx_start) volt_r <= volt_nxt;
  end

  // Table index = phase * 4D >> 32, split into quadrant and offset
  logic [PHASE_W+IBW-1:0] iprod;
  logic [IW-1:0] idx, r1, r2;
  logic [1:0]    quad, quad_c;
  logic [RW-1:0] roff, addr_sin, addr_cos;
  logic          neg_sin_r, neg_cos_r;

  vpd_smul #(.AW(PHASE_W), .BW(IBW), .DW(DIGIT_W)) u_imul (
    .clk(clk), .rst_n(rst_n), .start(idx_start), .a(phase_sum), .b(IBW'(D4)),
    .done(idx_done), .prod(iprod)
  );

  always_comb begin
    idx     = iprod[PHASE_W +: IW];
    quad[1] = idx >= IW'(2 * SINE_TABLE_DEPTH);
    r1      = quad[1] ? idx - IW'(2 * SINE_TABLE_DEPTH) : idx;
    quad[0] = r1 >= IW'(SINE_TABLE_DEPTH);
    r2      = quad[0] ? r1 - IW'(SINE_TABLE_DEPTH) : r1;
    roff    = r2[RW-1:0];
    quad_c  = quad + 2'd1;
    addr_sin = quad[0]   ? RW'(SINE_TABLE_DEPTH) - roff : roff;
    addr_cos = quad_c[0] ? RW'(SINE_TABLE_DEPTH) - roff : roff;
  end

  always_ff @(posedge clk) begin
    if (rom_en) begin
      neg_sin_r <= quad[1];
      neg_cos_r <= quad_c[1];
    end
  end

  logic [TRIG_W-1:0] sin_mag, cos_mag;

  vpd_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk(clk), .rd_en(rom_en), .addr_a(addr_sin), .addr_b(addr_cos),
    .data_a(sin_mag), .data_b(cos_mag)
  );

  // Amplitude scaling; floor of signed product via two's complement top half
  logic [FIELD_W+TRIG_W-1:0] aprod, bprod;
  logic [PHASE_W-1:0]        a_sv, b_sv;

  vpd_smul #(.AW(FIELD_W), .BW(TRIG_W), .DW(DIGIT_W)) u_amul (
    .clk(clk), .rst_n(rst_n), .start(scale_start), .a(volt_r), .b(cos_mag),
    .done(amul_done), .prod(aprod)
  );

  vpd_smul #(.AW(FIELD_W), .BW(TRIG_W), .DW(DIGIT_W)) u_bmul (
    .clk(clk), .rst_n(rst_n), .start(scale_start), .a(volt_r), .b(sin_mag),
    .done(bmul_done), .prod(bprod)
  );

  assign a_sv = neg_cos_r ? PHASE_W'(0) - PHASE_W'(aprod) : PHASE_W'(aprod);
  assign b_sv = neg_sin_r ? PHASE_W'(0) - PHASE_W'(bprod) : PHASE_W'(bprod);

  // Output register
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [5*FIELD_W-1:0]         out_tdata_r, out_tdata_nxt;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {b_sv[PHASE_W-1:FIELD_W], a_sv[PHASE_W-1:FIELD_W],
                        phase_acc_r[PHASE_W-1:FIELD_W], volt_r, freq_now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOLD |-> out_tvalid_r)
    else $error("hold state entered with free output slot");

  a_freq_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && min_freq_r <= max_freq_r) |->
      (freq_now_r >= min_freq_r && freq_now_r <= max_freq_r))
    else $error("frequency outside configured limits");

  a_phase_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(phase_acc_r)) |-> $past(state_r) == ST_MUL)
    else $error("phase accumulator changed outside multiply step");

  a_muls_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (vmul_done == pmul_done) && (amul_done == bmul_done))
    else $error("parallel multipliers out of step");

  a_load_after_scale: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_SCALE || $past(state_r) == ST_HOLD))
    else $error("result presented without finished scaling");
`endif

endmodule
